[src/pst_pkg.sv]
// Shared types and constants for the point spanning tree block.
package pst_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int IDX_BITS       = 6;

    typedef struct packed {
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic        last_point;
    } pst_in_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] parent_index;
        logic [IDX_BITS-1:0] child_index;
        logic                last_edge;
    } pst_out_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                wr;
        logic [IDX_BITS-1:0] wr_idx;
        logic                clear;
        logic                mark;
        logic                upd;
        logic [IDX_BITS-1:0] pick_idx;
    } pst_ctrl_t;

endpackage

[src/prim_point_spanning_tree_core.sv]
// Top level: point loader, round sequencer and the chain of point cells.
//
// Input channel (in_valid/in_ready/in_data): one point per transfer, stored
// in the next free slot; slot 0 is the root. Points beyond MAX_POINTS are
// dropped. A transfer with last_point set starts the tree build and
// in_ready stays low until the final edge has been loaded for output.
// Output channel (out_valid/out_ready/out_data): one edge per added point,
// in order of addition, last_edge set on the final one; a single point
// gives no edge.
// Points are loaded back to back while idle. Each round broadcasts the
// newest tree point to all cells (three-stage distance update), then lets
// the running winner ripple through the chain of MAX_POINTS cells, one
// cell a cycle.
// The edge is held in an output register; while the receiver stalls the
// next round waits for it.
// Reset (rst_n, asynchronous, active low) empties the point set and
// drops any edge not yet transferred.
module prim_point_spanning_tree_core #(
    parameter int MAX_POINTS = pst_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = pst_pkg::DEF_COORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pst_pkg::pst_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pst_pkg::pst_out_t out_data
);
    import pst_pkg::*;

    localparam int CW       = COORD_BITS;
    localparam int DW       = 2 * CW + 1;
    localparam int CNTW     = $clog2(MAX_POINTS + 1);
    localparam int WAIT_LEN = MAX_POINTS + 4;
    localparam int WW       = $clog2(WAIT_LEN);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next, n_reg, n_next, edges_reg, edges_next;
    logic [WW-1:0]   wait_reg, wait_next;
    logic [CW-1:0]   root_x_reg, root_y_reg;
    logic            out_valid_reg, out_valid_next;
    pst_out_t        out_reg, out_next;
    pst_ctrl_t       ctrl;
    logic [CW-1:0]   bx, by, in_x, in_y;
    logic            in_xfer, last_e;

    logic                tf [MAX_POINTS+1];
    logic [DW-1:0]       td [MAX_POINTS+1];
    logic [CW-1:0]       ta [MAX_POINTS+1];
    logic [CW-1:0]       tm [MAX_POINTS+1];
    logic [IDX_BITS-1:0] ti [MAX_POINTS+1];
    logic [IDX_BITS-1:0] tp [MAX_POINTS+1];
    logic [CW-1:0]       tx [MAX_POINTS+1];
    logic [CW-1:0]       ty [MAX_POINTS+1];

    assign tf[0] = 1'b0;
    assign td[0] = '0;
    assign ta[0] = '0;
    assign tm[0] = '0;
    assign ti[0] = '0;
    assign tp[0] = '0;
    assign tx[0] = '0;
    assign ty[0] = '0;

    for (genvar g = 0; g < MAX_POINTS; g++)
    begin : g_cell
        pst_cell #(.CW(CW), .CNTW(CNTW), .IDX(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .bx(bx), .by(by), .n(n_reg),
            .ti_found(tf[g]), .ti_d(td[g]), .ti_a(ta[g]), .ti_m(tm[g]),
            .ti_idx(ti[g]), .ti_par(tp[g]), .ti_x(tx[g]), .ti_y(ty[g]),
            .to_found(tf[g+1]), .to_d(td[g+1]), .to_a(ta[g+1]), .to_m(tm[g+1]),
            .to_idx(ti[g+1]), .to_par(tp[g+1]), .to_x(tx[g+1]), .to_y(ty[g+1])
        );
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_x      = CW'(in_data.x_coord);
    assign in_y      = CW'(in_data.y_coord);
    assign last_e    = ((CNTW + 1)'(edges_reg) + (CNTW + 1)'(2)) == (CNTW + 1)'(n_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        edges_next     = edges_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ctrl           = '0;
        bx             = in_x;
        by             = in_y;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CNTW'(MAX_POINTS))
                    begin
                        ctrl.wr     = 1'b1;
                        ctrl.wr_idx = IDX_BITS'(count_reg);
                        count_next  = count_reg + 1'b1;
                    end
                    if (in_data.last_point)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                count_next = '0;
                n_next     = count_reg;
                edges_next = '0;
                if (count_reg <= CNTW'(1))
                    state_next = S_IDLE;
                else
                begin
                    // seed every link with the root
                    ctrl.clear    = 1'b1;
                    ctrl.upd      = 1'b1;
                    ctrl.pick_idx = '0;
                    bx            = root_x_reg;
                    by            = root_y_reg;
                    wait_next     = '0;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WW'(WAIT_LEN - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.parent_index = tp[MAX_POINTS];
                    out_next.child_index  = ti[MAX_POINTS];
                    out_next.last_edge    = last_e;
                    ctrl.mark             = 1'b1;
                    ctrl.upd              = 1'b1;
                    ctrl.pick_idx         = ti[MAX_POINTS];
                    bx                    = tx[MAX_POINTS];
                    by                    = ty[MAX_POINTS];
                    edges_next            = edges_reg + 1'b1;
                    wait_next             = '0;
                    state_next            = last_e ? S_IDLE : S_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            edges_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            edges_reg     <= edges_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (ctrl.wr && count_reg == '0)
        begin
            root_x_reg <= in_x;
            root_y_reg <= in_y;
        end
    end

endmodule

[src/pst_cell.sv]
// One point cell: holds a point and its best tree link, passes the running winner on.
module pst_cell #(
    parameter int CW   = pst_pkg::DEF_COORD_BITS,
    parameter int CNTW = 7,
    parameter int IDX  = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pst_pkg::pst_ctrl_t           ctrl,
    input  logic [CW-1:0]                bx,
    input  logic [CW-1:0]                by,
    input  logic [CNTW-1:0]              n,
    input  logic                         ti_found,
    input  logic [2*CW:0]                ti_d,
    input  logic [CW-1:0]                ti_a,
    input  logic [CW-1:0]                ti_m,
    input  logic [pst_pkg::IDX_BITS-1:0] ti_idx,
    input  logic [pst_pkg::IDX_BITS-1:0] ti_par,
    input  logic [CW-1:0]                ti_x,
    input  logic [CW-1:0]                ti_y,
    output logic                         to_found,
    output logic [2*CW:0]                to_d,
    output logic [CW-1:0]                to_a,
    output logic [CW-1:0]                to_m,
    output logic [pst_pkg::IDX_BITS-1:0] to_idx,
    output logic [pst_pkg::IDX_BITS-1:0] to_par,
    output logic [CW-1:0]                to_x,
    output logic [CW-1:0]                to_y
);
    import pst_pkg::*;

    localparam int DW = 2 * CW + 1;
    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

    logic [CW-1:0]       x_reg, y_reg;
    logic                in_tree_reg, ok_reg;
    logic [DW-1:0]       bd_reg;
    logic [CW-1:0]       ba_reg, bm_reg;
    logic [IDX_BITS-1:0] bp_reg;

    logic                v1_reg, v2_reg;
    logic [CW-1:0]       dx_reg, dy_reg, m1_reg, a2_reg, m2_reg;
    logic [IDX_BITS-1:0] p1_reg, p2_reg;
    logic [2*CW-1:0]     sqx_reg, sqy_reg;

    logic [CW-1:0]   dx_next, dy_next, m1_next;
    logic [2*CW-1:0] sqx_next, sqy_next;
    logic [DW-1:0]   d3;
    logic            take, active, wins;

    always_comb
    begin
        dx_next  = (x_reg >= bx) ? x_reg - bx : bx - x_reg;
        dy_next  = (y_reg >= by) ? y_reg - by : by - y_reg;
        m1_next  = (x_reg >= bx) ? x_reg : bx;
        sqx_next = dx_reg * dx_reg;
        sqy_next = dy_reg * dy_reg;
        d3       = DW'(sqx_reg) + DW'(sqy_reg);
        take = v2_reg && !in_tree_reg &&
               (!ok_reg || d3 < bd_reg ||
                (d3 == bd_reg && (a2_reg > ba_reg || (a2_reg == ba_reg && m2_reg > bm_reg))));
        active = (IDX != 0) && (CNTW'(IDX) < n) && !in_tree_reg;
        wins = active && (!ti_found || bd_reg < ti_d ||
               (bd_reg == ti_d && (ba_reg > ti_a || (ba_reg == ti_a && bm_reg > ti_m))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg <= 1'b0;
            ok_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            to_found    <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.upd;
            v2_reg <= v1_reg;
            if (ctrl.clear)
            begin
                in_tree_reg <= (IDX == 0);
                ok_reg      <= 1'b0;
            end
            else
            begin
                if (ctrl.mark && ctrl.pick_idx == MY_IDX)
                    in_tree_reg <= 1'b1;
                if (take)
                    ok_reg <= 1'b1;
            end
            to_found <= wins ? 1'b1 : ti_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && ctrl.wr_idx == MY_IDX)
        begin
            x_reg <= bx;
            y_reg <= by;
        end
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        m1_reg  <= m1_next;
        p1_reg  <= ctrl.pick_idx;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        a2_reg  <= dy_reg;
        m2_reg  <= m1_reg;
        p2_reg  <= p1_reg;
        if (take)
        begin
            bd_reg <= d3;
            ba_reg <= a2_reg;
            bm_reg <= m2_reg;
            bp_reg <= p2_reg;
        end
        // pass on the better of the incoming winner and this cell
        to_d   <= wins ? bd_reg : ti_d;
        to_a   <= wins ? ba_reg : ti_a;
        to_m   <= wins ? bm_reg : ti_m;
        to_idx <= wins ? MY_IDX : ti_idx;
        to_par <= wins ? bp_reg : ti_par;
        to_x   <= wins ? x_reg  : ti_x;
        to_y   <= wins ? y_reg  : ti_y;
    end

endmodule
